// ===== hw/rtl/dmart_pkg.sv =====
// ----------------------------------------------------------------------------
// dmart_pkg
// Shared types and constants for the DMA ring tracker with adaptive IRQ.
// ----------------------------------------------------------------------------
package dmart_pkg;

    // Parameter defaults
    localparam int RING_CHUNKS_DEF = 8;
    localparam int CHUNK_BYTES_DEF = 65536;

    // Request types
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_POLL   = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_ENABLED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VALID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_BASE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_MAX    = 3'd4;

    // Register reset values
    localparam logic        RING_ENABLED_RST = 1'b0;
    localparam logic        SOURCE_VALID_RST = 1'b1;
    localparam logic [31:0] RING_BASE_RST    = 32'd0;
    localparam logic [22:0] THRESH_MIN_RST   = 23'd65536;
    localparam logic [22:0] THRESH_MAX_RST   = 23'd262144;

    // Poll budget
    localparam logic [10:0] BUDGET_MAX = 11'd1024;
    localparam logic [10:0] BUDGET_MIN = 11'd64;
    localparam logic [10:0] BUDGET_RST = 11'd256;

    // IRQ threshold
    localparam logic [22:0] THRESH_RST     = 23'd65536;
    localparam int          THRESH_BLK_SH  = 7;
    localparam logic [21:0] THRESH_REG_EN  = 22'h200000;

    // Fill tiers in percent (strictly above)
    localparam int FILL_TIER_HI  = 75;
    localparam int FILL_TIER_MID = 50;
    localparam int FILL_TIER_LO  = 25;
    localparam int FILL_SCALE    = 100;

    // Throttle at three quarters full
    localparam int THROTTLE_NUM = 3;
    localparam int THROTTLE_DEN = 4;

    typedef struct packed {
        logic        ring_enabled;
        logic        source_valid;
        logic [31:0] ring_base_addr;
        logic [22:0] thresh_min_bytes;
        logic [22:0] thresh_max_bytes;
    } dmart_cfg_t;

    typedef struct packed {
        logic [2:0]  avail_chunks;
        logic        throttle;
        logic        start_poll;
        logic [10:0] chunks_consumed;
        logic [10:0] chunks_delivered;
        logic [10:0] budget_now;
        logic        thresh_write;
        logic [21:0] thresh_reg_word;
        logic [22:0] threshold_now;
    } dmart_result_t;

endpackage

// ===== hw/rtl/dmart_cfg.sv =====
// ----------------------------------------------------------------------------
// dmart_cfg
// Configuration register file; plain indexed writes, no read-back.
// ----------------------------------------------------------------------------
module dmart_cfg
    import dmart_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output dmart_cfg_t            cfg
);

    dmart_cfg_t cfg_reg;
    dmart_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_RING_ENABLED: cfg_next.ring_enabled     = cfg_data[0];
                CFG_SOURCE_VALID: cfg_next.source_valid     = cfg_data[0];
                CFG_RING_BASE:    cfg_next.ring_base_addr   = cfg_data;
                CFG_THRESH_MIN:   cfg_next.thresh_min_bytes = cfg_data[22:0];
                CFG_THRESH_MAX:   cfg_next.thresh_max_bytes = cfg_data[22:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ring_enabled     <= RING_ENABLED_RST;
            cfg_reg.source_valid     <= SOURCE_VALID_RST;
            cfg_reg.ring_base_addr   <= RING_BASE_RST;
            cfg_reg.thresh_min_bytes <= THRESH_MIN_RST;
            cfg_reg.thresh_max_bytes <= THRESH_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/dmart_step.sv =====
// ----------------------------------------------------------------------------
// dmart_step
// Single-pass update: pointer sample or poll pass against current ring state.
// ----------------------------------------------------------------------------
module dmart_step
    import dmart_pkg::*;
#(
    parameter int RING_CHUNKS = RING_CHUNKS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int IDX_W       = $clog2(RING_CHUNKS)
)
(
    input  dmart_cfg_t    cfg,
    input  logic          req_type,
    input  logic [31:0]   write_pointer,
    input  logic          pointer_read_ok,
    input  logic [IDX_W-1:0] head,
    input  logic [IDX_W-1:0] tail,
    input  logic [IDX_W-1:0] last_chunk,
    input  logic [10:0]   budget,
    input  logic [22:0]   threshold,
    input  logic          pending,
    output logic [IDX_W-1:0] head_next,
    output logic [IDX_W-1:0] tail_next,
    output logic [IDX_W-1:0] last_chunk_next,
    output logic [10:0]   budget_next,
    output logic [22:0]   threshold_next,
    output logic          pending_next,
    output dmart_result_t res
);

    localparam int CB_LOG = $clog2(CHUNK_BYTES);
    localparam int CNT_W  = (IDX_W > 11) ? IDX_W : 11;
    localparam int PCT_W  = IDX_W + 7;

    localparam logic [IDX_W-1:0] THROTTLE_LVL =
        IDX_W'(RING_CHUNKS * THROTTLE_NUM / THROTTLE_DEN);
    // floor(fill*100/N) > T  <=>  fill*100 >= (T+1)*N
    localparam logic [PCT_W-1:0] TIER_HI  = PCT_W'((FILL_TIER_HI + 1) * RING_CHUNKS);
    localparam logic [PCT_W-1:0] TIER_MID = PCT_W'((FILL_TIER_MID + 1) * RING_CHUNKS);
    localparam logic [PCT_W-1:0] TIER_LO  = PCT_W'((FILL_TIER_LO + 1) * RING_CHUNKS);

    logic [31:0]      ptr_off;
    logic [IDX_W-1:0] chunk;
    logic [IDX_W-1:0] delta;
    logic [IDX_W-1:0] fill_pre;
    logic [IDX_W-1:0] fill_post;
    logic [CNT_W-1:0] consumed_w;
    logic [10:0]      consumed;
    logic [10:0]      delivered;
    logic [10:0]      half;
    logic [11:0]      dbl;
    logic [PCT_W-1:0] fill_pct;
    logic [23:0]      nt;
    logic [15:0]      blk;

    always_comb
    begin
        ptr_off    = write_pointer - cfg.ring_base_addr;
        chunk      = ptr_off[CB_LOG +: IDX_W];
        delta      = chunk - last_chunk;
        fill_pre   = head - tail;
        consumed_w = (CNT_W'(budget) < CNT_W'(fill_pre)) ? CNT_W'(budget)
                                                           : CNT_W'(fill_pre);
        consumed   = 11'(consumed_w);
        delivered  = cfg.source_valid ? consumed : 11'd0;
        half       = budget >> 1;
        dbl        = {budget, 1'b0};
        fill_post  = head - (tail + IDX_W'(consumed_w));
        fill_pct   = PCT_W'(fill_post) * PCT_W'(FILL_SCALE);

        head_next       = head;
        tail_next       = tail;
        last_chunk_next = last_chunk;
        budget_next     = budget;
        threshold_next  = threshold;
        pending_next    = pending;
        nt              = {1'b0, threshold};
        blk             = '0;

        res                  = '0;
        res.budget_now       = budget;
        res.threshold_now    = threshold;

        case (req_type)
            REQ_SAMPLE:
            begin
                if (pointer_read_ok)
                begin
                    if (delta == '0)
                        delta = IDX_W'(1);
                    last_chunk_next = chunk;
                end
                else
                begin
                    delta = IDX_W'(1);
                end
                head_next = head + delta;
                res.throttle = cfg.ring_enabled &&
                               ((head_next - tail) >= THROTTLE_LVL);
                if (!pending)
                begin
                    pending_next   = 1'b1;
                    res.start_poll = 1'b1;
                end
                res.avail_chunks = 3'(head_next - tail);
            end
            default:
            begin
                if (cfg.ring_enabled)
                begin
                    tail_next            = tail + IDX_W'(consumed_w);
                    res.chunks_consumed  = consumed;
                    res.chunks_delivered = delivered;

                    if (delivered >= half)
                        budget_next = (dbl > 12'(BUDGET_MAX)) ? BUDGET_MAX : dbl[10:0];
                    else if (delivered == 11'd0)
                        budget_next = (half > BUDGET_MIN) ? half : BUDGET_MIN;

                    if (fill_pct >= TIER_HI)
                        nt = {1'b0, cfg.thresh_max_bytes};
                    else if (fill_pct >= TIER_MID)
                        nt = {cfg.thresh_min_bytes, 1'b0};
                    else if (fill_pct >= TIER_LO)
                        nt = {1'b0, cfg.thresh_min_bytes};
                    else
                        nt = {2'b00, cfg.thresh_min_bytes[22:1]};
                    if (nt < {1'b0, cfg.thresh_min_bytes})
                        nt = {1'b0, cfg.thresh_min_bytes};
                    if (nt > {1'b0, cfg.thresh_max_bytes})
                        nt = {1'b0, cfg.thresh_max_bytes};

                    if (nt[22:0] != threshold)
                    begin
                        // 23-bit threshold >> 7 never exceeds the 16-bit field
                        blk                 = nt[22:THRESH_BLK_SH];
                        threshold_next      = nt[22:0];
                        res.thresh_write    = 1'b1;
                        res.thresh_reg_word = THRESH_REG_EN | 22'(blk);
                    end
                    res.avail_chunks = 3'(fill_post);
                    pending_next     = (fill_post != '0);
                end
                else
                begin
                    res.avail_chunks = 3'(fill_pre);
                    pending_next     = (fill_pre != '0);
                end
                res.start_poll = pending_next;
            end
        endcase

        res.budget_now    = budget_next;
        res.threshold_now = threshold_next;
    end

endmodule

// ===== hw/rtl/dma_ring_tracker_adaptive_irq.sv =====
// A result is registered at the edge that accepts its request.
// One request per cycle while the output is not stalled; the next state is ready at the same edge.
// A stalled result holds in the output register and stalls the input side.
// Reset (async, active low) restores ring indices, budget 256, threshold
// 65536, no poll pending and the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// dma_ring_tracker_adaptive_irq
// Chunked DMA ring tracker with adaptive poll budget and IRQ threshold.
// ----------------------------------------------------------------------------
module dma_ring_tracker_adaptive_irq
    import dmart_pkg::*;
#(
    parameter int RING_CHUNKS = RING_CHUNKS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [31:0]           write_pointer,
    input  logic                  pointer_read_ok,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            avail_chunks,
    output logic                  throttle,
    output logic                  start_poll,
    output logic [10:0]           chunks_consumed,
    output logic [10:0]           chunks_delivered,
    output logic [10:0]           budget_now,
    output logic                  thresh_write,
    output logic [21:0]           thresh_reg_word,
    output logic [22:0]           threshold_now
);

    localparam int IDX_W = $clog2(RING_CHUNKS);

    dmart_cfg_t       cfg;
    dmart_result_t    res;
    dmart_result_t    res_reg;

    logic [IDX_W-1:0] head_reg,       head_next;
    logic [IDX_W-1:0] tail_reg,       tail_next;
    logic [IDX_W-1:0] last_chunk_reg, last_chunk_next;
    logic [10:0]      budget_reg,     budget_next;
    logic [22:0]      threshold_reg,  threshold_next;
    logic             pending_reg,    pending_next;
    logic             out_valid_reg,  out_valid_next;
    logic             accept;

    dmart_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    dmart_step #(
        .RING_CHUNKS (RING_CHUNKS),
        .CHUNK_BYTES (CHUNK_BYTES),
        .IDX_W       (IDX_W)
    ) u_step (
        .cfg             (cfg),
        .req_type        (req_type),
        .write_pointer   (write_pointer),
        .pointer_read_ok (pointer_read_ok),
        .head            (head_reg),
        .tail            (tail_reg),
        .last_chunk      (last_chunk_reg),
        .budget          (budget_reg),
        .threshold       (threshold_reg),
        .pending         (pending_reg),
        .head_next       (head_next),
        .tail_next       (tail_next),
        .last_chunk_next (last_chunk_next),
        .budget_next     (budget_next),
        .threshold_next  (threshold_next),
        .pending_next    (pending_next),
        .res             (res)
    );

    // Take a new request whenever the result register is free or draining
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            last_chunk_reg <= '0;
            budget_reg     <= BUDGET_RST;
            threshold_reg  <= THRESH_RST;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                head_reg       <= head_next;
                tail_reg       <= tail_next;
                last_chunk_reg <= last_chunk_next;
                budget_reg     <= budget_next;
                threshold_reg  <= threshold_next;
                pending_reg    <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign out_valid        = out_valid_reg;
    assign avail_chunks     = res_reg.avail_chunks;
    assign throttle         = res_reg.throttle;
    assign start_poll       = res_reg.start_poll;
    assign chunks_consumed  = res_reg.chunks_consumed;
    assign chunks_delivered = res_reg.chunks_delivered;
    assign budget_now       = res_reg.budget_now;
    assign thresh_write     = res_reg.thresh_write;
    assign thresh_reg_word  = res_reg.thresh_reg_word;
    assign threshold_now    = res_reg.threshold_now;

`ifndef SYNTHESIS
    // Budget only ever doubles or halves from a power of two, within limits
    a_budget_range: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(budget_reg) && budget_reg >= BUDGET_MIN && budget_reg <= BUDGET_MAX)
        else $error("poll budget out of range");

    a_word_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && thresh_write |->
            thresh_reg_word == (THRESH_REG_EN | 22'(threshold_now[22:THRESH_BLK_SH])))
        else $error("threshold word does not match threshold");

    a_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !thresh_write |-> thresh_reg_word == '0)
        else $error("threshold word set without write");

    a_sample_xor_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && throttle |-> chunks_consumed == '0 && !thresh_write)
        else $error("throttle reported from a poll pass");

    a_state_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(head_reg) && $stable(tail_reg) && $stable(budget_reg))
        else $error("ring state moved without a request");
`endif

endmodule

// ===== tb/tb_dma_ring_tracker_adaptive_irq.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dma_ring_tracker_adaptive_irq
// Self-checking bench for the DMA ring tracker. A short table of requests
// covers reset values, pointer extremes, failed reads, budget floor and the
// threshold clamps; random phases with varied register settings follow.
// A behavioural tracker in the bench predicts every result the table does not give.
// ----------------------------------------------------------------------------
module tb_dma_ring_tracker_adaptive_irq;
    import dmart_pkg::*;

    localparam longint unsigned RING_BYTES =
        longint'(RING_CHUNKS_DEF) * longint'(CHUNK_BYTES_DEF);
    localparam int unsigned     BLK_FIELD_MAX = 32'h0000_FFFF;
    localparam int unsigned     THROTTLE_LEVEL = RING_CHUNKS_DEF * THROTTLE_NUM / THROTTLE_DEN;
    localparam int              PHASES = 6;
    localparam int              PHASE_REQUESTS = 215;
    localparam int              TIMEOUT_NS = 2_400_000;

    typedef enum logic { ROW_REQUEST, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic                   req;
        logic [31:0]            wp;
        logic                   ok;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        bit                     known;
        dmart_result_t          exp;
    } step_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  req_type;
    logic [31:0]           write_pointer;
    logic                  pointer_read_ok;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            avail_chunks;
    logic                  throttle;
    logic                  start_poll;
    logic [10:0]           chunks_consumed;
    logic [10:0]           chunks_delivered;
    logic [10:0]           budget_now;
    logic                  thresh_write;
    logic [21:0]           thresh_reg_word;
    logic [22:0]           threshold_now;

    // register shadows
    logic        reg_ring_en   = RING_ENABLED_RST;
    logic        reg_src_valid = SOURCE_VALID_RST;
    logic [31:0] reg_base      = RING_BASE_RST;
    logic [22:0] reg_min       = THRESH_MIN_RST;
    logic [22:0] reg_max       = THRESH_MAX_RST;

    // tracker state
    logic [2:0]  trk_head         = '0;
    logic [2:0]  trk_tail         = '0;
    logic [2:0]  trk_last_chunk   = '0;
    int unsigned trk_budget       = 32'(BUDGET_RST);
    int unsigned trk_threshold    = 32'(THRESH_RST);
    logic        trk_poll_pending = 1'b0;

    dmart_result_t awaited_results[$];
    step_row_t     directed_rows[$];
    int            mismatches = 0;
    int            burst_left = 0;

    dma_ring_tracker_adaptive_irq u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .write_pointer    (write_pointer),
        .pointer_read_ok  (pointer_read_ok),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .avail_chunks     (avail_chunks),
        .throttle         (throttle),
        .start_poll       (start_poll),
        .chunks_consumed  (chunks_consumed),
        .chunks_delivered (chunks_delivered),
        .budget_now       (budget_now),
        .thresh_write     (thresh_write),
        .thresh_reg_word  (thresh_reg_word),
        .threshold_now    (threshold_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [2:0] ring_fill();
        ring_fill = trk_head - trk_tail;
    endfunction

    // Works out the result of one accepted request and advances the tracker.
    function automatic dmart_result_t track_request(input logic req, input logic [31:0] wp,
                                                    input logic ok);
        dmart_result_t r;
        logic [31:0]   rel;
        logic [2:0]    chunk;
        logic [2:0]    delta;
        int unsigned   avail;
        int unsigned   take;
        int unsigned   pct;
        int unsigned   mn;
        int unsigned   mx;
        int unsigned   nt;
        int unsigned   blk;
        r = '0;
        if (req == REQ_SAMPLE)
        begin
            delta = 3'd1;
            if (ok)
            begin
                rel   = wp - reg_base;
                chunk = 3'((64'(rel) % RING_BYTES) / 64'(CHUNK_BYTES_DEF));
                delta = chunk - trk_last_chunk;
                if (delta == 3'd0)
                    delta = 3'd1;
                trk_last_chunk = chunk;
            end
            trk_head   = trk_head + delta;
            r.throttle = reg_ring_en && (32'(ring_fill()) >= THROTTLE_LEVEL);
            if (!trk_poll_pending)
            begin
                trk_poll_pending = 1'b1;
                r.start_poll     = 1'b1;
            end
        end
        else
        begin
            if (reg_ring_en)
            begin
                avail    = 32'(ring_fill());
                take     = (trk_budget < avail) ? trk_budget : avail;
                trk_tail = trk_tail + 3'(take);
                r.chunks_consumed  = 11'(take);
                r.chunks_delivered = reg_src_valid ? 11'(take) : 11'd0;
                if (32'(r.chunks_delivered) >= trk_budget / 2)
                    trk_budget = (trk_budget * 2 < 32'(BUDGET_MAX)) ? trk_budget * 2
                                                                     : 32'(BUDGET_MAX);
                else if (r.chunks_delivered == 11'd0)
                    trk_budget = (trk_budget / 2 > 32'(BUDGET_MIN)) ? trk_budget / 2
                                                                     : 32'(BUDGET_MIN);

                mn  = 32'(reg_min);
                mx  = 32'(reg_max);
                pct = 32'(ring_fill()) * FILL_SCALE / RING_CHUNKS_DEF;
                if (pct > FILL_TIER_HI)
                    nt = mx;
                else if (pct > FILL_TIER_MID)
                    nt = mn * 2;
                else if (pct > FILL_TIER_LO)
                    nt = mn;
                else
                    nt = mn / 2;
                // raise to min first, so max wins when software sets min above max
                if (nt < mn)
                    nt = mn;
                if (nt > mx)
                    nt = mx;
                if (nt != trk_threshold)
                begin
                    trk_threshold = nt;
                    blk = nt >> THRESH_BLK_SH;
                    if (blk > BLK_FIELD_MAX)
                        blk = BLK_FIELD_MAX;
                    r.thresh_write    = 1'b1;
                    r.thresh_reg_word = THRESH_REG_EN | 22'(blk);
                end
            end
            trk_poll_pending = 1'b0;
            if (ring_fill() != 3'd0)
            begin
                trk_poll_pending = 1'b1;
                r.start_poll     = 1'b1;
            end
        end
        r.avail_chunks  = ring_fill();
        r.budget_now    = 11'(trk_budget);
        r.threshold_now = 23'(trk_threshold);
        return r;
    endfunction

    function automatic void add_req(input logic req, input logic [31:0] wp, input logic ok);
        step_row_t row;
        row      = '{kind: ROW_REQUEST, default: '0};
        row.req  = req;
        row.wp   = wp;
        row.ok   = ok;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_known(input logic req, input logic [31:0] wp, input logic ok,
                                      input dmart_result_t exp);
        step_row_t row;
        row       = '{kind: ROW_REQUEST, default: '0};
        row.req   = req;
        row.wp    = wp;
        row.ok    = ok;
        row.known = 1'b1;
        row.exp   = exp;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        step_row_t row;
        row         = '{kind: ROW_WRITE, default: '0};
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endfunction

    task automatic report(input string msg);
        mismatches++;
        $display("%0t ns  ERROR  %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Register writes only once every request has come back.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_RING_ENABLED: reg_ring_en   = val[0];
            CFG_SOURCE_VALID: reg_src_valid = val[0];
            CFG_RING_BASE:    reg_base      = val;
            CFG_THRESH_MIN:   reg_min       = val[22:0];
            CFG_THRESH_MAX:   reg_max       = val[22:0];
            default: ;
        endcase
    endtask

    task automatic issue_request(input logic req, input logic [31:0] wp, input logic ok,
                                 input bit known, input dmart_result_t exp);
        dmart_result_t predicted;
        int            gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        burst_left--;
        in_valid        <= 1'b1;
        req_type        <= req;
        write_pointer   <= wp;
        pointer_read_ok <= ok;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = track_request(req, wp, ok);
        awaited_results.push_back(known ? exp : predicted);
    endtask

    // Receiver: segments of free flow, random stalls, a fixed pattern and long holds.
    initial
    begin
        int seg;
        int len;
        int mode;
        seg = 0;
        out_stall <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            seg++;
            mode = (seg % 4 == 3) ? 3 : $urandom_range(0, 2);
            len  = (mode == 3) ? 48 + $urandom_range(0, 32) : $urandom_range(20, 120);
            for (int c = 0; c < len; c++)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 35);
                    2: out_stall <= ((c % 5) >= 3);
                    default: out_stall <= 1'b1;
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        dmart_result_t e;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_results.size() == 0)
                report("result with no request outstanding");
            else
            begin
                e = awaited_results.pop_front();
                check_field("avail_chunks", 32'(avail_chunks), 32'(e.avail_chunks));
                check_field("throttle", 32'(throttle), 32'(e.throttle));
                check_field("start_poll", 32'(start_poll), 32'(e.start_poll));
                check_field("chunks_consumed", 32'(chunks_consumed),
                            32'(e.chunks_consumed));
                check_field("chunks_delivered", 32'(chunks_delivered),
                            32'(e.chunks_delivered));
                check_field("budget_now", 32'(budget_now), 32'(e.budget_now));
                check_field("thresh_write", 32'(thresh_write), 32'(e.thresh_write));
                check_field("thresh_reg_word", 32'(thresh_reg_word),
                            32'(e.thresh_reg_word));
                check_field("threshold_now", 32'(threshold_now), 32'(e.threshold_now));
            end
        end
    end

    initial
    begin
        logic [31:0] cursor;
        logic [31:0] wp;
        logic        ok;
        logic        en;
        logic        sv;
        logic [31:0] base;
        logic [22:0] mn;
        logic [22:0] mx;

        rst_n           <= 1'b0;
        cfg_write_en    <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        req_type        <= REQ_SAMPLE;
        write_pointer   <= '0;
        pointer_read_ok <= 1'b0;

        // reset state, ring disabled
        add_known(REQ_SAMPLE, 32'h0000_0000, 1'b1,
                  '{3'd1, 1'b0, 1'b1, 11'd0, 11'd0, BUDGET_RST, 1'b0, 22'd0, THRESH_RST});
        add_known(REQ_POLL, 32'h0000_0000, 1'b0,
                  '{3'd1, 1'b0, 1'b1, 11'd0, 11'd0, BUDGET_RST, 1'b0, 22'd0, THRESH_RST});
        // top of the address space lands in the last chunk and wraps the head
        add_known(REQ_SAMPLE, 32'hFFFF_FFFF, 1'b1,
                  '{3'd0, 1'b0, 1'b0, 11'd0, 11'd0, BUDGET_RST, 1'b0, 22'd0, THRESH_RST});
        add_req(REQ_SAMPLE, 32'h0000_0000, 1'b0);
        add_write(CFG_RING_ENABLED, 32'd1);
        add_req(REQ_SAMPLE, 32'h0003_0000, 1'b1);
        add_req(REQ_SAMPLE, 32'h0003_8000, 1'b1);   // same chunk: counts as one
        add_req(REQ_SAMPLE, 32'h0006_FFFF, 1'b1);
        add_req(REQ_SAMPLE, 32'h0006_0000, 1'b0);
        add_req(REQ_POLL, 32'h0000_0000, 1'b1);
        // empty passes walk the budget down to its floor
        add_req(REQ_POLL, 32'h0000_0000, 1'b1);
        add_req(REQ_POLL, 32'h0000_0000, 1'b1);
        add_req(REQ_POLL, 32'h0000_0000, 1'b1);
        add_req(REQ_POLL, 32'h0000_0000, 1'b1);
        add_write(CFG_SOURCE_VALID, 32'd0);
        add_req(REQ_SAMPLE, 32'h0001_0000, 1'b1);
        add_req(REQ_POLL, 32'h0000_0000, 1'b1);
        add_write(CFG_THRESH_MIN, 32'd128);
        add_write(CFG_THRESH_MAX, 32'd8388607);
        add_write(CFG_RING_BASE, 32'hFFFF_FFFF);
        add_req(REQ_SAMPLE, 32'h0000_0000, 1'b1);
        add_req(REQ_POLL, 32'h0000_0000, 1'b1);
        // min above max: max wins
        add_write(CFG_THRESH_MIN, 32'd8388607);
        add_write(CFG_THRESH_MAX, 32'd128);
        add_req(REQ_POLL, 32'hFFFF_FFFF, 1'b0);
        add_write(CFG_THRESH_MAX, 32'd8388607);
        add_req(REQ_SAMPLE, 32'h7FFF_FFFF, 1'b1);
        add_req(REQ_POLL, 32'h0000_0000, 1'b1);
        add_write(CFG_SOURCE_VALID, 32'd1);
        add_req(REQ_SAMPLE, 32'h8000_0000, 1'b1);
        add_req(REQ_POLL, 32'h0000_0000, 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                issue_request(directed_rows[i].req, directed_rows[i].wp, directed_rows[i].ok,
                              directed_rows[i].known, directed_rows[i].exp);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            en   = (p != 1);
            sv   = (p != 2);
            base = $urandom;
            mn   = 23'($urandom_range(128, 8388607));
            mx   = 23'($urandom_range(128, 8388607));
            case (p)
                0:
                begin
                    base = '0;
                    mn   = THRESH_MIN_RST;
                    mx   = THRESH_MAX_RST;
                end
                2:
                begin
                    base = 32'hFFFF_FFFF;
                    mn   = 23'd128;
                    mx   = 23'd8388607;
                end
                3:
                begin
                    mn = 23'd8388607;
                    mx = 23'd8388607;
                end
                4:
                begin
                    mn = 23'($urandom_range(4194304, 8388607));
                    mx = 23'($urandom_range(128, 4194303));
                end
                5:
                begin
                    mn = 23'd128;
                    mx = 23'd128;
                end
                default: ;
            endcase
            write_register(CFG_RING_ENABLED, {31'd0, en});
            write_register(CFG_SOURCE_VALID, {31'd0, sv});
            write_register(CFG_RING_BASE, base);
            write_register(CFG_THRESH_MIN, {9'd0, mn});
            write_register(CFG_THRESH_MAX, {9'd0, mx});

            cursor = $urandom_range(0, RING_CHUNKS_DEF - 1);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if ($urandom_range(0, 99) < 28)
                    issue_request(REQ_POLL, $urandom, 1'($urandom), 1'b0, '0);
                else
                begin
                    // mostly a pointer that moves forward through the ring
                    if ($urandom_range(0, 99) < 80)
                    begin
                        cursor = cursor + $urandom_range(0, 3);
                        wp = reg_base + cursor * CHUNK_BYTES_DEF
                             + $urandom_range(0, CHUNK_BYTES_DEF - 1);
                        ok = ($urandom_range(0, 9) != 0);
                    end
                    else
                    begin
                        wp = $urandom;
                        ok = 1'($urandom);
                    end
                    issue_request(REQ_SAMPLE, wp, ok, 1'b0, '0);
                end
            end
        end

        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
